// ===== rtl/core/brb_pkg.sv =====
// Shared types, codes and constants of the block ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

    // Built sizes (defaults of the top-level parameters)
    localparam int MAX_BLOCK_BYTES_DEF = 64;
    localparam int MAX_BLOCKS_DEF      = 16;

    // Register reset values
    localparam logic [6:0] CFG_BYTES_RST  = 7'd64;
    localparam logic [4:0] CFG_BLOCKS_RST = 5'd16;

    // Field widths fixed by the interface
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Widest block index carried in a queued job (MAX_BLOCKS up to 256)
    localparam int BLK_MAX_W = 8;

    // Depth of the job queue between front and back
    localparam int JOB_DEPTH = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EMPTY = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_BYTES   = 2'd0,
        CFG_BLOCKS_IN_USE = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } t_back_state;

    // One unit of work for the back end: either a single status result or
    // a block read of cnt bytes starting at block blk.
    typedef struct packed {
        logic                 is_read;
        logic [BLK_MAX_W-1:0] blk;
        logic [LIMIT_W-1:0]   cnt;
        logic                 accepted;
        logic                 space_left;
    } t_job;

endpackage

// ===== rtl/core/brb_if.sv =====
// Request, result and register-write channel interfaces.
`timescale 1ns / 1ps

interface brb_in_if;
    import brb_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [BYTE_W-1:0]  data_byte;
    logic [LIMIT_W-1:0] read_limit;

    modport source (output valid, output command, output data_byte, output read_limit,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input read_limit,
                    output ready);
endinterface

interface brb_out_if;
    import brb_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              accepted;
    logic              space_left;

    modport source (output valid, output out_byte, output last, output accepted,
                    output space_left, input ready);
    modport sink   (input valid, input out_byte, input last, input accepted,
                    input space_left, output ready);
endinterface

interface brb_cfg_if;
    import brb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/brb_queue.sv =====
// Small job queue between the front end and the back end.
`timescale 1ns / 1ps

module brb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brb_pkg::t_job i_job,
    input  logic          i_pop,
    output brb_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import brb_pkg::*;

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    t_job             r_q [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(JOB_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    assign o_head  = r_q[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(JOB_DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/brb_front.sv =====
// Front end: register file, ring pointers, byte writes and job classification.
`timescale 1ns / 1ps

module brb_front #(
    parameter int MAX_BLOCK_BYTES = brb_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS      = brb_pkg::MAX_BLOCKS_DEF,
    localparam int OFF_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1,
    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int AW    = BLK_W + OFF_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [brb_pkg::CMD_W-1:0]      i_command,
    input  logic [brb_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic [brb_pkg::LIMIT_W-1:0]    i_read_limit,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [brb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // job queue
    output logic                           o_push,
    output brb_pkg::t_job                  o_job,
    input  logic                           i_q_full,
    // back end has issued the final byte of a block read
    input  logic                           i_read_done,
    output logic                           o_rd_busy,
    // store write port
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [brb_pkg::BYTE_W-1:0]     o_wr_data
);
    import brb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PEND_W = $clog2(JOB_DEPTH + 2);

    logic [6:0]        r_block_bytes, n_block_bytes;
    logic [4:0]        r_blocks_in_use, n_blocks_in_use;
    logic [BLK_W-1:0]  r_read_block, n_read_block;
    logic [BLK_W-1:0]  r_write_block, n_write_block;
    logic [OFF_W-1:0]  r_write_offset, n_write_offset;
    logic [CNT_W-1:0]  r_free_blocks, n_free_blocks;
    logic [PEND_W-1:0] r_pend, n_pend;

    logic [6:0]         nb;
    logic [CNT_W-1:0]   nk;
    logic               accept;
    logic               has_free;
    logic [6:0]         off_p1;
    logic [CNT_W-1:0]   wb_p1;
    logic [CNT_W-1:0]   rb_p1;
    logic [LIMIT_W-1:0] rd_len;

    function automatic logic [CNT_W-1:0] clamp_blocks(input logic [4:0] v);
        logic [CNT_W-1:0] r;
        if (v == 5'd0) begin
            r = CNT_W'(1);
        end else if (9'(v) > 9'(MAX_BLOCKS)) begin
            r = CNT_W'(MAX_BLOCKS);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    always_comb begin
        if (r_block_bytes == 7'd0) begin
            nb = 7'd1;
        end else if (r_block_bytes > 7'(MAX_BLOCK_BYTES)) begin
            nb = 7'(MAX_BLOCK_BYTES);
        end else begin
            nb = r_block_bytes;
        end
    end

    assign nk       = clamp_blocks(r_blocks_in_use);
    assign has_free = (r_free_blocks != '0);
    assign o_rd_busy = (r_pend != '0);

    // Hold byte writes while a block read is still outstanding: the freed
    // block may be the one the next write lands in. Hold every request while
    // a register write is offered, as the register write takes the cycle.
    assign o_in_ready  = !i_cfg_valid && !i_q_full &&
                         !((t_cmd'(i_command) == CMD_WRITE) && o_rd_busy);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign off_p1 = 7'(r_write_offset) + 7'd1;
    assign wb_p1  = CNT_W'(r_write_block) + CNT_W'(1);
    assign rb_p1  = CNT_W'(r_read_block) + CNT_W'(1);

    always_comb begin
        if (i_read_limit < nb) begin
            rd_len = i_read_limit;
        end else begin
            rd_len = nb;
        end
        if (rd_len == '0) begin
            rd_len = LIMIT_W'(1);
        end
    end

    assign o_wr_addr = {r_write_block, r_write_offset};
    assign o_wr_data = i_data_byte;

    always_comb begin
        n_block_bytes   = r_block_bytes;
        n_blocks_in_use = r_blocks_in_use;
        n_read_block    = r_read_block;
        n_write_block   = r_write_block;
        n_write_offset  = r_write_offset;
        n_free_blocks   = r_free_blocks;
        o_push          = 1'b0;
        o_wr_en         = 1'b0;
        o_job           = '{is_read: 1'b0, blk: '0, cnt: LIMIT_W'(1),
                            accepted: 1'b0, space_left: has_free};

        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_BYTES: begin
                    n_block_bytes  = i_cfg_wdata;
                    n_read_block   = '0;
                    n_write_block  = '0;
                    n_write_offset = '0;
                    n_free_blocks  = nk;
                end
                CFG_BLOCKS_IN_USE: begin
                    n_blocks_in_use = i_cfg_wdata[4:0];
                    n_read_block    = '0;
                    n_write_block   = '0;
                    n_write_offset  = '0;
                    n_free_blocks   = clamp_blocks(i_cfg_wdata[4:0]);
                end
                default: ;
            endcase
        end else if (accept) begin
            o_push = 1'b1;
            unique case (t_cmd'(i_command))
                CMD_WRITE: begin
                    if (has_free) begin
                        o_wr_en = 1'b1;
                        if (off_p1 >= nb) begin
                            // block full: commit it and advance
                            n_write_offset = '0;
                            n_write_block  = (wb_p1 == nk) ? '0 : BLK_W'(wb_p1);
                            n_free_blocks  = r_free_blocks - CNT_W'(1);
                        end else begin
                            n_write_offset = OFF_W'(off_p1);
                        end
                        o_job.accepted   = 1'b1;
                        o_job.space_left = (n_free_blocks != '0);
                    end
                end
                CMD_READ: begin
                    if (r_free_blocks < nk) begin
                        o_job.is_read  = 1'b1;
                        o_job.blk      = BLK_MAX_W'(r_read_block);
                        o_job.cnt      = rd_len;
                        o_job.accepted = 1'b1;
                        n_read_block   = (rb_p1 == nk) ? '0 : BLK_W'(rb_p1);
                        n_free_blocks  = r_free_blocks + CNT_W'(1);
                    end
                end
                CMD_EMPTY: begin
                    n_read_block     = '0;
                    n_write_block    = '0;
                    n_write_offset   = '0;
                    n_free_blocks    = nk;
                    o_job.accepted   = 1'b1;
                    o_job.space_left = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pend = r_pend;
        if ((o_push && o_job.is_read) && !i_read_done) begin
            n_pend = r_pend + PEND_W'(1);
        end else if (!(o_push && o_job.is_read) && i_read_done) begin
            n_pend = r_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes   <= CFG_BYTES_RST;
            r_blocks_in_use <= CFG_BLOCKS_RST;
            r_read_block    <= '0;
            r_write_block   <= '0;
            r_write_offset  <= '0;
            r_free_blocks   <= clamp_blocks(CFG_BLOCKS_RST);
            r_pend          <= '0;
        end else begin
            r_block_bytes   <= n_block_bytes;
            r_blocks_in_use <= n_blocks_in_use;
            r_read_block    <= n_read_block;
            r_write_block   <= n_write_block;
            r_write_offset  <= n_write_offset;
            r_free_blocks   <= n_free_blocks;
            r_pend          <= n_pend;
        end
    end

endmodule

// ===== rtl/core/brb_back.sv =====
// Back end: block store, read sequencer and result output register.
`timescale 1ns / 1ps

module brb_back #(
    parameter int MAX_BLOCK_BYTES = brb_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS      = brb_pkg::MAX_BLOCKS_DEF,
    localparam int OFF_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1,
    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int AW    = BLK_W + OFF_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // store write port
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [brb_pkg::BYTE_W-1:0] i_wr_data,
    // job queue
    input  brb_pkg::t_job              i_job,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    output logic                       o_read_done,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [brb_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_out_last,
    output logic                       o_out_accepted,
    output logic                       o_out_space_left
);
    import brb_pkg::*;

    localparam int DEPTH = MAX_BLOCKS * (1 << OFF_W);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_back_state        r_state, n_state;
    logic [LIMIT_W-1:0] r_idx;
    logic [LIMIT_W-1:0] r_cnt;
    logic [BLK_W-1:0]   r_blk;

    // issue stage (memory read in flight)
    logic r_s1_vld, r_s1_data, r_s1_last, r_s1_acc, r_s1_space;
    // output register
    logic              r_o_vld, r_o_last, r_o_acc, r_o_space;
    logic [BYTE_W-1:0] r_o_byte;

    logic          o_take, s1_adv, s1_free, stream_last;
    logic          issue, rd_en;
    logic [AW-1:0] rd_addr;
    logic          s1_data, s1_last, s1_acc, s1_space;

    assign o_take      = !r_o_vld || i_out_ready;
    assign s1_adv      = r_s1_vld && o_take;
    assign s1_free     = !r_s1_vld || s1_adv;
    assign stream_last = ((r_idx + LIMIT_W'(1)) == r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop && i_job.is_read && (i_job.cnt != LIMIT_W'(1))) begin
                    n_state = BK_STREAM;
                end
            end
            BK_STREAM: begin
                if (issue && stream_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        issue       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        s1_data     = 1'b0;
        s1_last     = 1'b1;
        s1_acc      = 1'b0;
        s1_space    = 1'b0;
        o_read_done = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && s1_free) begin
                    o_pop = 1'b1;
                    issue = 1'b1;
                    if (i_job.is_read) begin
                        rd_en       = 1'b1;
                        rd_addr     = {i_job.blk[BLK_W-1:0], OFF_W'(0)};
                        s1_data     = 1'b1;
                        s1_last     = (i_job.cnt == LIMIT_W'(1));
                        s1_acc      = 1'b1;
                        s1_space    = 1'b1;
                        o_read_done = (i_job.cnt == LIMIT_W'(1));
                    end else begin
                        s1_acc   = i_job.accepted;
                        s1_space = i_job.space_left;
                    end
                end
            end
            BK_STREAM: begin
                if (s1_free) begin
                    issue       = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = {r_blk, r_idx[OFF_W-1:0]};
                    s1_data     = 1'b1;
                    s1_last     = stream_last;
                    s1_acc      = 1'b1;
                    s1_space    = 1'b1;
                    o_read_done = stream_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blk <= i_job.blk[BLK_W-1:0];
            r_cnt <= i_job.cnt;
            r_idx <= LIMIT_W'(1);
        end else if (issue) begin
            r_idx <= r_idx + LIMIT_W'(1);
        end
        if (issue) begin
            r_s1_data  <= s1_data;
            r_s1_last  <= s1_last;
            r_s1_acc   <= s1_acc;
            r_s1_space <= s1_space;
        end
        if (s1_adv) begin
            r_o_byte  <= r_s1_data ? r_rd_data : '0;
            r_o_last  <= r_s1_last;
            r_o_acc   <= r_s1_acc;
            r_o_space <= r_s1_space;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_out_byte       = r_o_byte;
    assign o_out_last       = r_o_last;
    assign o_out_accepted   = r_o_acc;
    assign o_out_space_left = r_o_space;

endmodule

// ===== rtl/core/block_ring_buffer.sv =====
// A taken request passes through the job queue, the issue stage and the output register; a
// block read offers its bytes in order. Throughput: one request per cycle while the job
// queue has room; a block read streams one byte per cycle from the single store read port
// while the result channel takes them, byte writes wait until every queued block read has
// issued its last store read, and requests wait while a register write is offered.
// Reset: pointers and offset cleared, 64 bytes per block, 16 blocks all free; store kept.
`timescale 1ns / 1ps

module block_ring_buffer #(
    parameter int MAX_BLOCK_BYTES = brb_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS      = brb_pkg::MAX_BLOCKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brb_in_if.sink    i_in,
    brb_out_if.source o_out,
    brb_cfg_if.sink   i_cfg
);
    import brb_pkg::*;

    localparam int OFF_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int AW    = BLK_W + OFF_W;

    logic              push, pop, q_empty, q_full, read_done, rd_busy;
    t_job              push_job, head_job;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    brb_front #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_BLOCKS      (MAX_BLOCKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_command    (i_in.command),
        .i_data_byte  (i_in.data_byte),
        .i_read_limit (i_in.read_limit),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_wdata  (i_cfg.wdata),
        .o_push       (push),
        .o_job        (push_job),
        .i_q_full     (q_full),
        .i_read_done  (read_done),
        .o_rd_busy    (rd_busy),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    brb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    brb_back #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_BLOCKS      (MAX_BLOCKS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (wr_en),
        .i_wr_addr        (wr_addr),
        .i_wr_data        (wr_data),
        .i_job            (head_job),
        .i_q_empty        (q_empty),
        .o_pop            (pop),
        .o_read_done      (read_done),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_out_byte       (o_out.out_byte),
        .o_out_last       (o_out.last),
        .o_out_accepted   (o_out.accepted),
        .o_out_space_left (o_out.space_left)
    );

    // The queue is never pushed while full nor popped while empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("job queue popped while empty");

    // A store write never races an outstanding block read.
    a_write_vs_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !rd_busy)
        else $error("store written while a block read is outstanding");

    // A final block byte read is only signalled for a read that was counted.
    a_done_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_done |-> rd_busy)
        else $error("block read finished with no read outstanding");

endmodule

// ===== dv/block_ring_buffer_tb.sv =====
// Self-checking testbench for the block ring buffer: directed and random requests.
`timescale 1ns / 1ps

module block_ring_buffer_tb;
    import brb_pkg::*;

    localparam int                 BLOCK_BYTES_MAX = MAX_BLOCK_BYTES_DEF;
    localparam int                 BLOCKS_MAX      = MAX_BLOCKS_DEF;
    localparam int                 STORE_BYTES     = BLOCK_BYTES_MAX * BLOCKS_MAX;
    localparam logic [CMD_W-1:0]   CMD_UNUSED      = 2'd3;
    localparam int                 SETTLE_CYCLES   = 8;
    localparam int                 HOLD_CYCLES     = 400;
    localparam int                 WATCHDOG_LIMIT  = 5000;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              accepted;
        logic              space_left;
    } ring_result_t;

    logic i_clk;
    logic i_rst_n;

    brb_in_if  req_if ();
    brb_out_if res_if ();
    brb_cfg_if cfg_if ();

    block_ring_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // Predicted ring state
    logic [BYTE_W-1:0]  ring_store [0:STORE_BYTES-1];
    logic [3:0]         rd_blk;
    logic [3:0]         wr_blk;
    logic [5:0]         wr_off;
    logic [4:0]         free_cnt;
    logic [6:0]         cfg_bytes;
    logic [4:0]         cfg_blocks;

    ring_result_t due_results [$];
    int           fail_count;
    int           burst_left;
    bit           gaps_on;
    bit           hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_bytes();
        if (cfg_bytes < 7'd1) return 1;
        if (int'(cfg_bytes) > BLOCK_BYTES_MAX) return BLOCK_BYTES_MAX;
        return int'(cfg_bytes);
    endfunction

    function automatic int ring_blocks();
        if (cfg_blocks < 5'd1) return 1;
        if (int'(cfg_blocks) > BLOCKS_MAX) return BLOCKS_MAX;
        return int'(cfg_blocks);
    endfunction

    function automatic int store_addr(logic [3:0] blk, int off);
        return int'(blk) * BLOCK_BYTES_MAX + (off % BLOCK_BYTES_MAX);
    endfunction

    task automatic ring_empty();
        rd_blk   = '0;
        wr_blk   = '0;
        wr_off   = '0;
        free_cnt = 5'(ring_blocks());
    endtask

    task automatic push_result(logic [BYTE_W-1:0] b, logic lst, logic acc, logic space);
        ring_result_t r;
        r.out_byte   = b;
        r.last       = lst;
        r.accepted   = acc;
        r.space_left = space;
        due_results.push_back(r);
    endtask

    // Work out the results of one taken request and advance the ring
    task automatic ring_apply(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                              logic [LIMIT_W-1:0] lim);
        int nb;
        int nk;
        int n;
        int i;
        nb = ring_bytes();
        nk = ring_blocks();
        case (cmd)
            CMD_WRITE: begin
                if (free_cnt == 5'd0) begin
                    push_result('0, 1'b1, 1'b0, 1'b0);
                end else begin
                    ring_store[store_addr(wr_blk, int'(wr_off))] = data;
                    if (int'(wr_off) + 1 >= nb) begin
                        wr_off   = '0;
                        wr_blk   = 4'((int'(wr_blk) + 1) % nk);
                        free_cnt = free_cnt - 5'd1;
                    end else begin
                        wr_off = wr_off + 6'd1;
                    end
                    push_result('0, 1'b1, 1'b1, free_cnt != 5'd0);
                end
            end
            CMD_READ: begin
                if (int'(free_cnt) >= nk) begin
                    push_result('0, 1'b1, 1'b0, free_cnt != 5'd0);
                end else begin
                    n = (int'(lim) < nb) ? int'(lim) : nb;
                    if (n == 0) n = 1;
                    for (i = 0; i < n; i++) begin
                        push_result(ring_store[store_addr(rd_blk, i)], i == n - 1, 1'b1, 1'b1);
                    end
                    rd_blk   = 4'((int'(rd_blk) + 1) % nk);
                    free_cnt = free_cnt + 5'd1;
                end
            end
            CMD_EMPTY: begin
                ring_empty();
                push_result('0, 1'b1, 1'b1, 1'b1);
            end
            default: begin
                push_result('0, 1'b1, 1'b0, free_cnt != 5'd0);
            end
        endcase
    endtask

    // Offer one request in bursts; valid stays high into the next call
    task automatic offer_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                 logic [LIMIT_W-1:0] lim);
        if (gaps_on && burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.data_byte  <= data;
        req_if.read_limit <= lim;
        do @(posedge i_clk); while (!req_if.ready);
        ring_apply(cmd, data, lim);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; the ring empties on each write
    task automatic configure_ring(logic [CFG_DATA_W-1:0] bytes_val,
                                  logic [CFG_DATA_W-1:0] blocks_val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_BLOCK_BYTES;
        cfg_if.wdata <= bytes_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_bytes = bytes_val;
        ring_empty();
        cfg_if.index <= CFG_BLOCKS_IN_USE;
        cfg_if.wdata <= blocks_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_blocks = blocks_val[4:0];
        ring_empty();
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return LIMIT_W'($urandom_range(65, 127));
        return LIMIT_W'($urandom_range(1, 64));
    endfunction

    task automatic mixed_traffic(int count);
        int k;
        int r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                offer_request(CMD_WRITE, BYTE_W'($urandom), pick_limit());
            end else if (r < 92) begin
                offer_request(CMD_READ, BYTE_W'($urandom), pick_limit());
            end else if (r < 96) begin
                offer_request(CMD_EMPTY, BYTE_W'($urandom), pick_limit());
            end else begin
                offer_request(CMD_UNUSED, BYTE_W'($urandom), pick_limit());
            end
        end
    endtask

    // Commit whole blocks, then read them back
    task automatic fill_and_read(int blocks, logic [LIMIT_W-1:0] lim);
        int k;
        int j;
        for (k = 0; k < blocks; k++) begin
            for (j = 0; j < ring_bytes(); j++) begin
                offer_request(CMD_WRITE, BYTE_W'($urandom), '0);
            end
        end
        for (k = 0; k < blocks; k++) begin
            offer_request(CMD_READ, '0, lim);
        end
    endtask

    task automatic test_directed();
        configure_ring(7'd2, 7'd2);
        offer_request(CMD_READ,   8'h00, 7'd1);
        offer_request(CMD_WRITE,  8'h00, 7'd1);
        offer_request(CMD_WRITE,  8'hFF, 7'd1);
        offer_request(CMD_WRITE,  8'hA5, 7'd1);
        offer_request(CMD_WRITE,  8'h5A, 7'd1);
        // ring full: byte is dropped
        offer_request(CMD_WRITE,  8'h3C, 7'd1);
        offer_request(CMD_READ,   8'h00, 7'd0);
        offer_request(CMD_READ,   8'h00, 7'd127);
        offer_request(CMD_READ,   8'h00, 7'd2);
        // partial block must stay unreadable
        offer_request(CMD_WRITE,  8'h55, 7'd1);
        offer_request(CMD_READ,   8'h00, 7'd64);
        offer_request(CMD_UNUSED, 8'hFF, 7'd127);
        offer_request(CMD_EMPTY,  8'h00, 7'd1);
        offer_request(CMD_WRITE,  8'hAA, 7'd1);
        offer_request(CMD_WRITE,  8'h0F, 7'd1);
        offer_request(CMD_READ,   8'h00, 7'd2);
        offer_request(CMD_WRITE,  8'h80, 7'd1);
        offer_request(CMD_EMPTY,  8'h00, 7'd1);
        offer_request(CMD_READ,   8'h00, 7'd64);
        wait_drained();
    endtask

    task automatic test_single_byte_ring();
        configure_ring(7'd1, 7'd1);
        mixed_traffic(50);
        wait_drained();
    endtask

    task automatic test_clamped_low();
        configure_ring(7'd0, 7'd0);
        mixed_traffic(30);
        wait_drained();
    endtask

    task automatic test_largest_blocks();
        configure_ring(7'd64, 7'd16);
        fill_and_read(1, 7'd64);
        fill_and_read(1, 7'd127);
        mixed_traffic(10);
        wait_drained();
    endtask

    task automatic test_clamped_high();
        configure_ring(7'h7F, 7'h7F);
        mixed_traffic(20);
        wait_drained();
    endtask

    task automatic test_mid_sizes();
        configure_ring(7'd5, 7'd3);
        mixed_traffic(60);
        fill_and_read(2, pick_limit());
        // back-to-back stretch with no gaps on the request side
        gaps_on = 1'b0;
        mixed_traffic(40);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_input_stall();
        configure_ring(7'd3, 7'd4);
        hold_req = 1'b1;
        mixed_traffic(90);
        wait_drained();
    endtask

    // Result side: stall on its own pattern, with a long hold-off on request
    initial begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(32, 256);
                end
                span--;
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= (span % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        ring_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: byte %02h last %0b acc %0b space %0b",
                         $time, res_if.out_byte, res_if.last, res_if.accepted,
                         res_if.space_left);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (res_if.out_byte !== want.out_byte || res_if.last !== want.last ||
                    res_if.accepted !== want.accepted ||
                    res_if.space_left !== want.space_left) begin
                    $display("%0t: expected byte %02h last %0b acc %0b space %0b, %s",
                             $time, want.out_byte, want.last, want.accepted,
                             want.space_left, "got:");
                    $display("%0t: actual   byte %02h last %0b acc %0b space %0b",
                             $time, res_if.out_byte, res_if.last, res_if.accepted,
                             res_if.space_left);
                    fail_count++;
                end
            end
        end
    end

    // Stop if no request, result or register write moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("block_ring_buffer_tb failed");
        $finish;
    end

    initial begin
        fail_count        = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        hold_req          = 1'b0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.command    <= CMD_WRITE;
        req_if.data_byte  <= '0;
        req_if.read_limit <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_BLOCK_BYTES;
        cfg_if.wdata      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_bytes  = CFG_BYTES_RST;
        cfg_blocks = CFG_BLOCKS_RST[4:0];
        ring_empty();

        test_directed();
        test_single_byte_ring();
        test_clamped_low();
        test_largest_blocks();
        test_clamped_high();
        test_mid_sizes();
        test_input_stall();

        wait_drained();
        if (fail_count == 0) begin
            $display("block_ring_buffer_tb passed");
        end else begin
            $display("block_ring_buffer_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/brb_pkg.sv
rtl/core/brb_if.sv
rtl/core/brb_queue.sv
rtl/core/brb_front.sv
rtl/core/brb_back.sv
rtl/core/block_ring_buffer.sv
dv/block_ring_buffer_tb.sv
